/* hw/rtl/ddf_pkg.sv */
// ----------------------------------------------------------------------------
// ddf_pkg - shared definitions for the DLE deframer
// Result kinds, frame phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ddf_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd3;

  // Frame phases
  localparam logic [PHASE_W-1:0] PH_HUNT     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT_ESC = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA_ESC = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE     = 2'd3;

  // Reset values (DLE, STX, ETX)
  localparam logic              RST_CHECK_ENABLE = 1'b1;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE  = 8'h10;
  localparam logic [BYTE_W-1:0] RST_START_CODE   = 8'h02;
  localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'h03;

  // Register file contents as seen by the deframer
  typedef struct packed {
    logic              check_enable;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } cfg_t;

endpackage

/* hw/rtl/dle_deframer_with_checksum_unit.sv */
// ----------------------------------------------------------------------------
// dle_deframer_with_checksum_unit - DLE/STX/ETX deframer with checksum
// Strips byte stuffing from a received stream and flags frame ends.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per beat (in_rx_byte), valid/ready.
//   out_* : zero or one result per byte: a payload byte (kind 0) or an end
//           marker (1 good, 2 checksum bad, 3 abort) with a zero byte.
//   cfg_* : register writes (index, data), always ready; write only while
//           no byte is in flight. Registers: check enable, escape, start
//           and end codes.
// Flow: a byte accepted into the input register is processed as it leaves
//   it, and its result, if any, is registered and offered from then on.
// Throughput: one byte per cycle while no result is held unaccepted, set by
//   the combinational phase/sum update between input and result registers.
// Reset: synchronous, active low; returns to hunting, clears the sum and
//   loads the DLE/STX/ETX defaults with checksum checking on.
// Stall: while a result is held unaccepted the input register fills and
//   in_ready drops; no beat is lost.
// ----------------------------------------------------------------------------
module dle_deframer_with_checksum_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ddf_pkg::BYTE_W-1:0]    in_rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ddf_pkg::KIND_W-1:0]    out_result_kind,
  output logic [ddf_pkg::BYTE_W-1:0]    out_payload_byte,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ddf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddf_pkg::BYTE_W-1:0]    cfg_data
);

  ddf_pkg::cfg_t cfg;

  logic                          s1_valid_r;
  logic [ddf_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                          s1_go;

  logic [ddf_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [ddf_pkg::BYTE_W-1:0]    sum_r, sum_nxt;

  logic                          res_vld;
  logic [ddf_pkg::KIND_W-1:0]    res_kind;
  logic [ddf_pkg::BYTE_W-1:0]    res_byte;

  logic                          out_valid_r;
  logic [ddf_pkg::KIND_W-1:0]    out_kind_r;
  logic [ddf_pkg::BYTE_W-1:0]    out_byte_r;

  // Registers
  ddf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  // Handshake: process the held byte when the result slot is free or freeing
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Deframing step
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    res_vld   = 1'b0;
    res_kind  = ddf_pkg::KIND_PAYLOAD;
    res_byte  = '0;
    case (phase_r)
      ddf_pkg::PH_HUNT_ESC: begin
        if (s1_byte_r == cfg.start_code) begin
          phase_nxt = ddf_pkg::PH_DATA;
          sum_nxt   = '0;
        end else begin
          phase_nxt = ddf_pkg::PH_HUNT;
        end
      end
      ddf_pkg::PH_DATA: begin
        if (s1_byte_r == cfg.escape_code) begin
          phase_nxt = ddf_pkg::PH_DATA_ESC;
        end else begin
          sum_nxt  = sum_r + s1_byte_r;
          res_vld  = 1'b1;
          res_byte = s1_byte_r;
        end
      end
      ddf_pkg::PH_DATA_ESC: begin
        res_vld = 1'b1;
        if (s1_byte_r == cfg.escape_code) begin
          // stuffed escape: literal byte, counted in the sum
          phase_nxt = ddf_pkg::PH_DATA;
          sum_nxt   = sum_r + s1_byte_r;
          res_byte  = s1_byte_r;
        end else if (s1_byte_r == cfg.end_code) begin
          if (cfg.check_enable) begin
            phase_nxt = ddf_pkg::PH_CHECK;
            res_vld   = 1'b0;
          end else begin
            phase_nxt = ddf_pkg::PH_HUNT;
            res_kind  = ddf_pkg::KIND_GOOD;
          end
        end else begin
          phase_nxt = ddf_pkg::PH_HUNT;
          res_kind  = ddf_pkg::KIND_ABORT;
        end
      end
      ddf_pkg::PH_CHECK: begin
        phase_nxt = ddf_pkg::PH_HUNT;
        res_vld   = 1'b1;
        res_kind  = (s1_byte_r == ~sum_r) ? ddf_pkg::KIND_GOOD : ddf_pkg::KIND_BAD;
      end
      default: begin
        // hunting, unused codes included
        phase_nxt = (s1_byte_r == cfg.escape_code) ? ddf_pkg::PH_HUNT_ESC
                                                   : ddf_pkg::PH_HUNT;
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ddf_pkg::PH_HUNT;
      sum_r   <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_vld;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_vld) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_payload_byte = out_byte_r;

  // Checks
  a_marker_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != ddf_pkg::KIND_PAYLOAD) |-> out_byte_r == '0)
    else $error("end marker carries a non-zero byte");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= ddf_pkg::PH_CHECK)
    else $error("frame phase left the used codes");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (phase_r == ddf_pkg::PH_HUNT_ESC) && (s1_byte_r == cfg.start_code)
    |=> (sum_r == '0) && (phase_r == ddf_pkg::PH_DATA))
    else $error("start pair did not open a fresh frame");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_byte_r))
    else $error("held byte lost during a stall");

endmodule

/* hw/rtl/ddf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ddf_cfg_regs - configuration registers of the DLE deframer
// Indexed write port; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module ddf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ddf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ddf_pkg::BYTE_W-1:0]    wr_data,
  output ddf_pkg::cfg_t                 cfg
);

  ddf_pkg::cfg_t cfg_r;
  ddf_pkg::cfg_t cfg_nxt;

  // Decode the write beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ddf_pkg::REG_CHECK_ENABLE: cfg_nxt.check_enable = wr_data[0];
        ddf_pkg::REG_ESCAPE_CODE:  cfg_nxt.escape_code  = wr_data;
        ddf_pkg::REG_START_CODE:   cfg_nxt.start_code   = wr_data;
        ddf_pkg::REG_END_CODE:     cfg_nxt.end_code     = wr_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable <= ddf_pkg::RST_CHECK_ENABLE;
      cfg_r.escape_code  <= ddf_pkg::RST_ESCAPE_CODE;
      cfg_r.start_code   <= ddf_pkg::RST_START_CODE;
      cfg_r.end_code     <= ddf_pkg::RST_END_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for dle_deframer_with_checksum_unit
// Feeds byte streams (well-formed frames with random payloads, bad checksums,
// aborts and line noise) under several code and checksum settings. A model
// of the deframer predicts every payload byte and end marker, and each
// result beat is checked against the oldest prediction. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES  = 150;

  typedef struct packed {
    logic [ddf_pkg::KIND_W-1:0] kind;
    logic [ddf_pkg::BYTE_W-1:0] data;
  } deframe_result_t;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_ABORT, FR_NOISE} frame_mode_t;

  // Deframer model plus the queue of results it has predicted
  class deframe_scoreboard;
    logic                        check_en;
    logic [ddf_pkg::BYTE_W-1:0]  esc_code;
    logic [ddf_pkg::BYTE_W-1:0]  stx_code;
    logic [ddf_pkg::BYTE_W-1:0]  etx_code;
    logic [ddf_pkg::PHASE_W-1:0] phase;
    logic [ddf_pkg::BYTE_W-1:0]  sum;
    deframe_result_t             pending_results[$];
    int                          errors;

    function void reset_state();
      check_en = ddf_pkg::RST_CHECK_ENABLE;
      esc_code = ddf_pkg::RST_ESCAPE_CODE;
      stx_code = ddf_pkg::RST_START_CODE;
      etx_code = ddf_pkg::RST_END_CODE;
      phase    = ddf_pkg::PH_HUNT;
      sum      = '0;
      errors   = 0;
      pending_results.delete();
    endfunction

    function void write_reg(logic [ddf_pkg::CFG_IDX_W-1:0] idx,
                            logic [ddf_pkg::BYTE_W-1:0] data);
      case (idx)
        ddf_pkg::REG_CHECK_ENABLE: check_en = data[0];
        ddf_pkg::REG_ESCAPE_CODE:  esc_code = data;
        ddf_pkg::REG_START_CODE:   stx_code = data;
        ddf_pkg::REG_END_CODE:     etx_code = data;
        default: ;
      endcase
    endfunction

    function void push(logic [ddf_pkg::KIND_W-1:0] kind, logic [ddf_pkg::BYTE_W-1:0] data);
      deframe_result_t r;
      r.kind = kind;
      r.data = data;
      pending_results.push_back(r);
    endfunction

    // One received byte: advance the phase and predict any result
    function void note_rx_byte(logic [ddf_pkg::BYTE_W-1:0] b);
      case (phase)
        ddf_pkg::PH_HUNT_ESC: begin
          if (b == stx_code) begin
            phase = ddf_pkg::PH_DATA;
            sum   = '0;
          end else begin
            phase = ddf_pkg::PH_HUNT;
          end
        end
        ddf_pkg::PH_DATA: begin
          if (b == esc_code) begin
            phase = ddf_pkg::PH_DATA_ESC;
          end else begin
            sum += b;
            push(ddf_pkg::KIND_PAYLOAD, b);
          end
        end
        ddf_pkg::PH_DATA_ESC: begin
          // escape test wins over end test when the codes coincide
          if (b == esc_code) begin
            phase = ddf_pkg::PH_DATA;
            sum += b;
            push(ddf_pkg::KIND_PAYLOAD, b);
          end else if (b == etx_code) begin
            if (check_en) begin
              phase = ddf_pkg::PH_CHECK;
            end else begin
              phase = ddf_pkg::PH_HUNT;
              push(ddf_pkg::KIND_GOOD, '0);
            end
          end else begin
            phase = ddf_pkg::PH_HUNT;
            push(ddf_pkg::KIND_ABORT, '0);
          end
        end
        ddf_pkg::PH_CHECK: begin
          phase = ddf_pkg::PH_HUNT;
          push((b == ~sum) ? ddf_pkg::KIND_GOOD : ddf_pkg::KIND_BAD, '0);
        end
        default: begin
          phase = (b == esc_code) ? ddf_pkg::PH_HUNT_ESC : ddf_pkg::PH_HUNT;
        end
      endcase
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [ddf_pkg::KIND_W-1:0] kind,
                               logic [ddf_pkg::BYTE_W-1:0] data);
      deframe_result_t want;
      if (pending_results.size() == 0) begin
        complain($sformatf("unexpected result: kind %0d byte %02h", kind, data));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind || data !== want.data)
        complain($sformatf(
          "result mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
          want.kind, want.data, kind, data));
    endfunction

    function void check_drained();
      foreach (pending_results[i])
        complain($sformatf("missing result: kind %0d byte %02h",
                           pending_results[i].kind, pending_results[i].data));
    endfunction
  endclass

  // Clock, reset and block inputs
  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic [ddf_pkg::BYTE_W-1:0]    in_rx_byte = '0;
  logic                          out_ready  = 1'b0;
  logic                          cfg_valid  = 1'b0;
  logic [ddf_pkg::CFG_IDX_W-1:0] cfg_index  = ddf_pkg::REG_CHECK_ENABLE;
  logic [ddf_pkg::BYTE_W-1:0]    cfg_data   = '0;

  logic                          in_ready;
  logic                          out_valid;
  logic                          cfg_ready;
  logic [ddf_pkg::KIND_W-1:0]    out_result_kind;
  logic [ddf_pkg::BYTE_W-1:0]    out_payload_byte;

  deframe_scoreboard sb = new;
  bit                no_idle = 1'b0;
  int                bytes_sent = 0;
  int                cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dle_deframer_with_checksum_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dle_deframer_with_checksum_unit] ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_result_kind, out_payload_byte);
  end

  // Result side back-pressure: a fresh stall before every beat
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input beat; entered and left just after the clock rises
  task automatic send_byte(input logic [ddf_pkg::BYTE_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  // Wait until every predicted result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddf_pkg::BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Only bit 0 of the check enable write counts; upper bits are junk
  task automatic load_config(input logic ce, input logic [ddf_pkg::BYTE_W-1:0] esc,
                             input logic [ddf_pkg::BYTE_W-1:0] stx,
                             input logic [ddf_pkg::BYTE_W-1:0] etx);
    settle();
    write_reg(ddf_pkg::REG_CHECK_ENABLE,
              (ddf_pkg::BYTE_W'($urandom) & 8'hFE) | ddf_pkg::BYTE_W'(ce));
    write_reg(ddf_pkg::REG_ESCAPE_CODE, esc);
    write_reg(ddf_pkg::REG_START_CODE, stx);
    write_reg(ddf_pkg::REG_END_CODE, etx);
    cfg_valid <= 1'b0;
  endtask

  // Payload bytes lean towards the codes and the extremes
  function automatic logic [ddf_pkg::BYTE_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0, 1: return sb.esc_code;
      2: return sb.etx_code;
      3: return sb.stx_code;
      4: return 8'h00;
      5: return 8'hFF;
      default: return ddf_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input frame_mode_t mode);
    int                         len;
    int                         n;
    logic [ddf_pkg::BYTE_W-1:0] b;
    logic [ddf_pkg::BYTE_W-1:0] sum;
    if (mode == FR_NOISE) begin
      n = $urandom_range(1, 6);
      repeat (n)
        send_byte(($urandom_range(0, 3) == 0) ? sb.esc_code : ddf_pkg::BYTE_W'($urandom));
      return;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    sum = '0;
    send_byte(sb.esc_code);
    send_byte(sb.stx_code);
    repeat (len) begin
      b = pick_payload();
      if (b == sb.esc_code) send_byte(b);
      send_byte(b);
      sum += b;
    end
    send_byte(sb.esc_code);
    if (mode == FR_ABORT) begin
      do b = ddf_pkg::BYTE_W'($urandom); while (b == sb.esc_code || b == sb.etx_code);
      send_byte(b);
      return;
    end
    send_byte(sb.etx_code);
    if (sb.check_en)
      send_byte((mode == FR_BAD_SUM) ? (~sum ^ ddf_pkg::BYTE_W'($urandom_range(1, 255)))
                                     : ~sum);
  endtask

  // Mostly good frames, with bad sums, aborts and noise mixed in
  task automatic run_random(input int budget);
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 12)      send_frame(FR_GOOD);
      else if (pick < 15) send_frame(FR_BAD_SUM);
      else if (pick < 17) send_frame(FR_ABORT);
      else                send_frame(FR_NOISE);
    end
    no_idle = 1'b0;
  endtask

  // Directed stream under reset codes: noise, escape twice while hunting,
  // a good frame with literal escape and end code as data, a bad checksum,
  // an abort
  logic [ddf_pkg::BYTE_W-1:0] directed_bytes[$] = '{
    8'h00, 8'hFF,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_ESCAPE_CODE,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_START_CODE, 8'h00, 8'hFF,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_ESCAPE_CODE,
    ddf_pkg::RST_END_CODE, ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_END_CODE, 8'hED,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_START_CODE, 8'h55,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_END_CODE, 8'h00,
    ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_START_CODE, 8'h7E,
    ddf_pkg::RST_ESCAPE_CODE, 8'h41
  };

  // Main sequence
  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    run_random(PHASE_BYTES);

    // checksum off, default codes
    load_config(1'b0, ddf_pkg::RST_ESCAPE_CODE, ddf_pkg::RST_START_CODE,
                ddf_pkg::RST_END_CODE);
    run_random(PHASE_BYTES);
    // extreme code values
    load_config(1'b1, 8'h00, 8'hFF, 8'h80);
    run_random(PHASE_BYTES);
    load_config(1'b1, 8'hFF, 8'h00, 8'h01);
    run_random(PHASE_BYTES);
    // start code equal to escape
    load_config(1'b0, 8'h7E, 8'h7E, 8'hA5);
    run_random(PHASE_BYTES);
    // end code equal to escape: escape pair always reads as a literal
    load_config(1'b1, 8'h55, 8'hAA, 8'h55);
    run_random(PHASE_BYTES);
    repeat (3) begin
      load_config(1'($urandom_range(0, 1)), ddf_pkg::BYTE_W'($urandom),
                  ddf_pkg::BYTE_W'($urandom), ddf_pkg::BYTE_W'($urandom));
      run_random(PHASE_BYTES);
    end

    settle();
    sb.check_drained();
    if (sb.errors == 0)
      $display("[dle_deframer_with_checksum_unit] OK");
    else
      $display("[dle_deframer_with_checksum_unit] ERROR");
    $finish;
  end

endmodule
